// ===== design/depth_to_scan_column_min_assert.svh =====
// Assertion macros used by the checker in dsc_checker.sv.
`ifndef DEPTH_TO_SCAN_COLUMN_MIN_ASSERT_SVH
`define DEPTH_TO_SCAN_COLUMN_MIN_ASSERT_SVH

// Implication checked at every rising clock edge, disabled during reset.
`define DSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/dsc_pkg.sv =====
// ---------------------------------------------------------------------------
// dsc_pkg
// Types and constants shared by the depth-to-scan column reducer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package dsc_pkg;
  localparam int COL_BITS   = 10;
  localparam int ROW_BITS   = 10;
  localparam int COORD_BITS = 16;
  localparam int RSQ_BITS   = 2 * COORD_BITS;
  localparam int RNG_BITS   = 16;
  localparam int ADDR_BITS  = 4;

  localparam logic [ADDR_BITS-1:0] REG_START  = 4'h0;
  localparam logic [ADDR_BITS-1:0] REG_END    = 4'h4;
  localparam logic [ADDR_BITS-1:0] REG_CUTOFF = 4'h8;

  typedef struct packed {
    logic [ROW_BITS-1:0]          pixel_row;
    logic [COL_BITS-1:0]          pixel_col;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] vz;
  } in_beat_t;

  typedef struct packed {
    logic [COL_BITS-1:0]          scan_column;
    logic                         found;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_z;
    logic [RNG_BITS-1:0]          range_mm;
  } out_beat_t;

  // Column entry stored in memory.
  typedef struct packed {
    logic                         valid;
    logic [RSQ_BITS-1:0]          rsq;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] z;
  } entry_t;

  // Root request from the update stage.
  typedef struct packed {
    logic                         go;
    logic [COL_BITS-1:0]          col;
    logic                         found;
    logic [RSQ_BITS-1:0]          rsq;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] z;
  } root_req_t;
endpackage

// ===== design/dsc_column_store.sv =====
// ---------------------------------------------------------------------------
// dsc_column_store
// Per-column best-point memory: one read port and one write port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module dsc_column_store import dsc_pkg::*; (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [COL_BITS-1:0] rd_addr,
  output entry_t              rd_data,
  input  logic                wr_en,
  input  logic [COL_BITS-1:0] wr_addr,
  input  entry_t              wr_data
);
  entry_t mem [0:(1<<COL_BITS)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== design/dsc_isqrt_pipe.sv =====
// ---------------------------------------------------------------------------
// dsc_isqrt_pipe
// Pipelined integer square root, one result bit per stage, with output fifo.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module dsc_isqrt_pipe import dsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  root_req_t req,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);
  localparam int NST = RNG_BITS;
  localparam int FD  = 32;
  localparam int FAW = $clog2(FD);
  localparam int IW  = $clog2(NST+2);
  localparam int OW  = FAW + 2;

  logic [NST:0]                 v_r;
  logic [RSQ_BITS:0]            rem_r [0:NST];
  logic [RNG_BITS-1:0]          res_r [0:NST];
  logic [COL_BITS-1:0]          col_r [0:NST];
  logic                         fnd_r [0:NST];
  logic signed [COORD_BITS-1:0] x_r   [0:NST];
  logic signed [COORD_BITS-1:0] z_r   [0:NST];

  out_beat_t      fifo_r [0:FD-1];
  logic [FAW-1:0] wp_r, rp_r;
  logic [FAW:0]   cnt_r;
  logic [IW-1:0]  inflight;
  logic [OW-1:0]  occ;
  logic push, pop;

  always_comb begin
    inflight = '0;
    for (int i = 0; i <= NST; i++) begin
      inflight = inflight + {{(IW-1){1'b0}}, v_r[i]};
    end
  end

  // Hold new requests while fifo space could run out; two more beats may
  // still be on their way from the update stage.
  assign occ  = OW'(cnt_r) + OW'(inflight);
  assign busy = occ >= OW'(FD - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NST-1:0], req.go};
    end
    rem_r[0] <= {1'b0, req.rsq};
    res_r[0] <= '0;
    col_r[0] <= req.col;
    fnd_r[0] <= req.found;
    x_r[0]   <= req.x;
    z_r[0]   <= req.z;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    localparam int SH = 2 * (NST - 1 - s);
    logic [RSQ_BITS+1:0] trial;
    logic [RSQ_BITS+1:0] cmp;
    always_comb begin
      cmp   = {1'b0, rem_r[s]} >> SH;
      trial = {{(RSQ_BITS+2-RNG_BITS-2){1'b0}}, res_r[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (cmp >= trial) begin
        rem_r[s+1] <= rem_r[s] - (RSQ_BITS+1)'(trial << SH);
        res_r[s+1] <= {res_r[s][RNG_BITS-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= rem_r[s];
        res_r[s+1] <= {res_r[s][RNG_BITS-2:0], 1'b0};
      end
      col_r[s+1] <= col_r[s];
      fnd_r[s+1] <= fnd_r[s];
      x_r[s+1]   <= x_r[s];
      z_r[s+1]   <= z_r[s];
    end
  end

  assign push = v_r[NST];
  assign pop  = out_valid && !out_stall;
  assign out_valid = cnt_r != '0;
  assign out_data  = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{FAW{1'b0}}, push} - {{FAW{1'b0}}, pop};
    end
    if (push) begin
      fifo_r[wp_r] <= '{scan_column: col_r[NST], found: fnd_r[NST],
                        near_x: fnd_r[NST] ? x_r[NST] : '0,
                        near_z: fnd_r[NST] ? z_r[NST] : '0,
                        range_mm: fnd_r[NST] ? res_r[NST] : '0};
    end
  end
endmodule

// ===== design/depth_to_scan_column_min.sv =====
// ---------------------------------------------------------------------------
// depth_to_scan_column_min
// Nearest point per image column from a raster stream of depth vertices.
// ---------------------------------------------------------------------------
// Input channel in_*: one vertex per beat (row, column, x, y, z), taken
// when in_valid is high and in_stall low; one beat per cycle while in_stall is low.
// Output channel out_*: one beat per column from left_cutoff on, on the last
// window row, carrying column, found flag, x, z and floor range in millimetres.
// A last-row vertex passes to its result through one memory read, one
// compare/update, a 16-stage square-root pipe and a small fifo.
// The column memory is read, then the updated entry is written back via wb;
// a later vertex of the same column in flight takes the entry from wb or wb2.
// A stalled receiver fills the 32-deep result fifo; in_stall rises while
// it could overflow, otherwise input is taken every cycle.
// Reset sets start_row 0, end_row 480, left_cutoff 120 and empties the
// pipe; the column memory is not cleared, as the first window row of
// each column rewrites its entry. Configure over cfg_* only while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module depth_to_scan_column_min import dsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  logic [ROW_BITS-1:0] start_r;
  logic [ROW_BITS:0]   end_r;
  logic [COL_BITS-1:0] cut_r;

  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr)
      REG_START:  cfg_prdata = {{(32-ROW_BITS){1'b0}}, start_r};
      REG_END:    cfg_prdata = {{(31-ROW_BITS){1'b0}}, end_r};
      REG_CUTOFF: cfg_prdata = {{(32-COL_BITS){1'b0}}, cut_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= (ROW_BITS+1)'(480);
      cut_r   <= COL_BITS'(120);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        REG_START:  start_r <= cfg_pwdata[ROW_BITS-1:0];
        REG_END:    end_r   <= cfg_pwdata[ROW_BITS:0];
        REG_CUTOFF: cut_r   <= cfg_pwdata[COL_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic busy;
  logic acc;
  assign in_stall = busy;
  assign acc = in_valid && !busy;

  // Stage 1: qualify and read memory.
  logic in_win;
  assign in_win = (in_data.pixel_col >= cut_r) && (end_r > {1'b0, start_r})
                  && (in_data.pixel_row >= start_r)
                  && ({1'b0, in_data.pixel_row} < end_r);

  logic                         s1_v_r, s1_first_r, s1_last_r, s1_ok_r;
  logic [COL_BITS-1:0]          s1_col_r;
  logic signed [COORD_BITS-1:0] s1_x_r, s1_z_r;
  logic [RSQ_BITS-1:0]          s1_rsq_r;
  logic [COORD_BITS-1:0]        ax, az;

  assign ax = in_data.vx[COORD_BITS-1] ? COORD_BITS'(-in_data.vx) : in_data.vx;
  assign az = in_data.vz[COORD_BITS-1] ? COORD_BITS'(-in_data.vz) : in_data.vz;

  logic [2*COORD_BITS-1:0] sqx_r, sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc && in_win;
    end
    s1_first_r <= in_data.pixel_row == start_r;
    s1_last_r  <= {1'b0, in_data.pixel_row} == end_r - 1'b1;
    s1_ok_r    <= (in_data.vx != '0) && (in_data.vy != '0) && (in_data.vz != '0);
    s1_col_r   <= in_data.pixel_col;
    s1_x_r     <= in_data.vx;
    s1_z_r     <= in_data.vz;
    sqx_r      <= ax * ax;
    sqz_r      <= az * az;
  end
  assign s1_rsq_r = RSQ_BITS'(sqx_r + sqz_r);

  entry_t rd_data;
  entry_t wb_r;
  logic   wb_v_r;
  logic [COL_BITS-1:0] wb_col_r;
  entry_t wb2_r;
  logic   wb2_v_r;
  logic [COL_BITS-1:0] wb2_col_r;

  dsc_column_store u_store (
    .clk(clk), .rd_en(acc), .rd_addr(in_data.pixel_col), .rd_data(rd_data),
    .wr_en(wb_v_r), .wr_addr(wb_col_r), .wr_data(wb_r)
  );

  // Stage 2: forward, compare, update.
  // wb2 holds the entry written on the same edge as this beat's read.
  entry_t cur, upd;
  logic   better;
  always_comb begin
    if (wb_v_r && wb_col_r == s1_col_r) begin
      cur = wb_r;
    end else if (wb2_v_r && wb2_col_r == s1_col_r) begin
      cur = wb2_r;
    end else begin
      cur = rd_data;
    end
    if (s1_first_r) cur.valid = 1'b0;
    better = s1_ok_r && (!cur.valid || s1_rsq_r < cur.rsq);
    upd = better ? entry_t'{valid: 1'b1, rsq: s1_rsq_r, x: s1_x_r, z: s1_z_r} : cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_v_r  <= 1'b0;
      wb2_v_r <= 1'b0;
    end else begin
      wb_v_r  <= s1_v_r;
      wb2_v_r <= wb_v_r;
    end
    wb_col_r  <= s1_col_r;
    wb_r      <= upd;
    wb2_col_r <= wb_col_r;
    wb2_r     <= wb_r;
  end

  root_req_t req;
  assign req = '{go: s1_v_r && s1_last_r, col: s1_col_r, found: upd.valid,
                 rsq: upd.rsq, x: upd.x, z: upd.z};

  dsc_isqrt_pipe u_root (
    .clk(clk), .rst_n(rst_n), .req(req), .busy(busy),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule

// ===== design/dsc_checker.sv =====
// ---------------------------------------------------------------------------
// dsc_checker
// Port-level checks on the reducer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "depth_to_scan_column_min_assert.svh"
module dsc_checker import dsc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);
  `DSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `DSC_ASSERT_IMPL(a_zero_miss, out_valid && !out_data.found,
                   out_data.near_x == '0 && out_data.near_z == '0 && out_data.range_mm == '0)
  `DSC_ASSERT_IMPL(a_range_ok, out_valid && out_data.found,
                   out_data.range_mm <= 16'd46341)
  `DSC_ASSERT_IMPL(a_stall_known, in_valid, !$isunknown(in_stall))
endmodule

bind depth_to_scan_column_min dsc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
